### hw/rtl/assert_macros.svh
// assertion macros used by the resampler core
// no dependencies; assertions compile away under SYNTHESIS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

### hw/rtl/stlr_pkg.sv
// package for the stereo linear resampler: sizes, defaults and sequencer states
// no dependencies
package stlr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_BITS_DEFAULT = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_L,
        ST_SUM_L,
        ST_MUL_R,
        ST_SUM_R
    } seq_state_t;

endpackage

### hw/rtl/stereo_linear_resampler_core.sv
// stereo linear interpolation resampler, top level
// depends on stlr_pkg and assert_macros.svh
//
// One stereo frame enters per request on the slave stream; s_tlast marks the last
// frame of a packet. A fractional read position (FRAC_BITS+4 bits, FRAC_BITS fraction
// bits) walks the interval between the held and the incoming frame, and every position
// below 1.0 makes one output: held + (incoming - held) * frac, truncated toward zero,
// after which the position advances by the step register (clamped on write to
// 1/16..8.0 frames, reset value 1.0). On a packet's last frame the positions in its own
// interval repeat that frame unchanged and nothing is held afterward. m_tlast marks the
// last output a frame causes; the first frame of a packet causes none unless it is also
// its last. A single shared multiplier serves both channels, so each output passes
// through five steps (position check, left multiply, left sum, right multiply, right
// sum); s_tready is low while a frame is processed. The last output waits in the
// output register while the next frame is taken.
module stereo_linear_resampler_core
    import stlr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [FRAC_BITS+3:0]  cfg_wr_data,   // step
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,       // left_in [15:0], right_in [31:16]
    input  logic                  s_tlast,       // packet_end
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,       // left_out [15:0], right_out [31:16]
    output logic                  m_tlast        // run_last
);

    localparam int PW = FRAC_BITS + 4;
    localparam int DW = SAMPLE_W + 1;
    localparam int MW = DW + FRAC_BITS + 1;
    localparam logic [PW-1:0] ONE      = PW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] TWO      = PW'(1) << (FRAC_BITS + 1);
    localparam logic [PW-1:0] NINE     = PW'(9) << FRAC_BITS;
    localparam logic [PW-1:0] STEP_MIN = PW'(1) << (FRAC_BITS - 4);
    localparam logic [PW-1:0] STEP_MAX = PW'(8) << FRAC_BITS;

    seq_state_t state_reg, state_next;

    logic [PW-1:0]          step_reg, step_next;
    logic [PW-1:0]          pos_reg, pos_next;
    logic                   held_valid_reg, held_valid_next;
    logic [SAMPLE_W-1:0]    held_l_reg, held_l_next;
    logic [SAMPLE_W-1:0]    held_r_reg, held_r_next;
    logic [SAMPLE_W-1:0]    cur_l_reg, cur_l_next;
    logic [SAMPLE_W-1:0]    cur_r_reg, cur_r_next;
    logic                   end_reg, end_next;
    logic                   repeat_reg, repeat_next;
    logic signed [MW-1:0]   prod_reg, prod_next;
    logic [SAMPLE_W-1:0]    lres_reg, lres_next;
    logic                   m_valid_reg, m_valid_next;
    logic [31:0]            m_data_reg, m_data_next;
    logic                   m_last_reg, m_last_next;

    logic signed [DW-1:0]   mul_a;
    logic signed [FRAC_BITS:0] mul_b;
    logic [SAMPLE_W-1:0]    base_s;
    logic signed [MW-1:0]   base;
    logic signed [MW-1:0]   total;
    logic signed [MW-1:0]   quot;
    logic                   corr;
    logic [SAMPLE_W-1:0]    lerp_res;
    logic [PW-1:0]          pos_adv;
    logic                   adv_last;
    logic                   out_free;

    // shared multiplier and truncating sum
    always_comb
    begin
        if (state_reg == ST_MUL_R)
        begin
            mul_a = $signed({cur_r_reg[SAMPLE_W-1], cur_r_reg})
                  - $signed({held_r_reg[SAMPLE_W-1], held_r_reg});
        end
        else
        begin
            mul_a = $signed({cur_l_reg[SAMPLE_W-1], cur_l_reg})
                  - $signed({held_l_reg[SAMPLE_W-1], held_l_reg});
        end
        mul_b = $signed({1'b0, pos_reg[FRAC_BITS-1:0]});
        base_s = (state_reg == ST_SUM_R) ? held_r_reg : held_l_reg;
        base = $signed({{(MW-SAMPLE_W-FRAC_BITS){base_s[SAMPLE_W-1]}}, base_s,
                        {FRAC_BITS{1'b0}}});
        total = base + prod_reg;
        quot = total >>> FRAC_BITS;
        corr = total[MW-1] && (|total[FRAC_BITS-1:0]);
        lerp_res = quot[SAMPLE_W-1:0] + SAMPLE_W'(corr);
        pos_adv = pos_reg + step_reg;
        adv_last = !(pos_adv < ONE) && !(!repeat_reg && end_reg && (pos_adv < TWO));
        out_free = !m_valid_reg || m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= ONE;
            pos_reg        <= '0;
            held_valid_reg <= 1'b0;
            held_l_reg     <= '0;
            held_r_reg     <= '0;
            end_reg        <= 1'b0;
            repeat_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            pos_reg        <= pos_next;
            held_valid_reg <= held_valid_next;
            held_l_reg     <= held_l_next;
            held_r_reg     <= held_r_next;
            end_reg        <= end_next;
            repeat_reg     <= repeat_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_l_reg  <= cur_l_next;
        cur_r_reg  <= cur_r_next;
        prod_reg   <= prod_next;
        lres_reg   <= lres_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        pos_next        = pos_reg;
        held_valid_next = held_valid_reg;
        held_l_next     = held_l_reg;
        held_r_next     = held_r_reg;
        cur_l_next      = cur_l_reg;
        cur_r_next      = cur_r_reg;
        end_next        = end_reg;
        repeat_next     = repeat_reg;
        prod_next       = prod_reg;
        lres_next       = lres_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        s_tready        = 1'b0;

        // step clamp on write
        if (cfg_wr_en)
        begin
            if (cfg_wr_data < STEP_MIN)
            begin
                step_next = STEP_MIN;
            end
            else if (cfg_wr_data > STEP_MAX)
            begin
                step_next = STEP_MAX;
            end
            else
            begin
                step_next = cfg_wr_data;
            end
        end

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cur_l_next = s_tdata[15:0];
                    cur_r_next = s_tdata[31:16];
                    end_next   = s_tlast;
                    if (held_valid_reg)
                    begin
                        repeat_next = 1'b0;
                        state_next  = ST_CHECK;
                    end
                    else if (s_tlast)
                    begin
                        repeat_next = 1'b1;
                        held_l_next = s_tdata[15:0];
                        held_r_next = s_tdata[31:16];
                        state_next  = ST_CHECK;
                    end
                    else
                    begin
                        held_l_next     = s_tdata[15:0];
                        held_r_next     = s_tdata[31:16];
                        held_valid_next = 1'b1;
                    end
                end
            end
            ST_CHECK:
            begin
                if (pos_reg < ONE)
                begin
                    state_next = ST_MUL_L;
                end
                else
                begin
                    pos_next = pos_reg - ONE;
                    if (!repeat_reg && end_reg)
                    begin
                        repeat_next = 1'b1;
                        held_l_next = cur_l_reg;
                        held_r_next = cur_r_reg;
                    end
                    else
                    begin
                        held_valid_next = !end_reg;
                        held_l_next     = end_reg ? '0 : cur_l_reg;
                        held_r_next     = end_reg ? '0 : cur_r_reg;
                        state_next      = ST_IDLE;
                    end
                end
            end
            ST_MUL_L:
            begin
                prod_next  = MW'(mul_a * mul_b);
                state_next = ST_SUM_L;
            end
            ST_SUM_L:
            begin
                lres_next  = lerp_res;
                state_next = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                prod_next  = MW'(mul_a * mul_b);
                state_next = ST_SUM_R;
            end
            ST_SUM_R:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {lerp_res, lres_reg};
                    m_last_next  = adv_last;
                    pos_next     = pos_adv;
                    state_next   = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `include "assert_macros.svh"

    `ASSERT_NEVER(a_pos_bound, clk, rst_n, pos_reg >= NINE, "read position beyond nine frames")
    `ASSERT_NEVER(a_step_range, clk, rst_n, (step_reg < STEP_MIN) || (step_reg > STEP_MAX), "step out of range")
    `ASSERT_PROP(a_frac_valid, clk, rst_n, (state_reg == ST_SUM_R) |-> (pos_reg < ONE), "interpolation at position past interval")
    `ASSERT_PROP(a_more_follow, clk, rst_n, (m_valid_reg && m_tready && !m_last_reg) |-> (state_reg != ST_IDLE), "sequencer idle before last output")

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// testbench for stereo_linear_resampler_core: a directed table, then random packets
// under changing flow control, each output checked against typed rows or an interpolation model
// depends on stlr_pkg and stereo_linear_resampler_core
module testbench
    import stlr_pkg::*;
();

    localparam int FRAC        = FRAC_BITS_DEFAULT;
    localparam int POS_W       = FRAC + 4;
    localparam logic [POS_W-1:0] ONE_POS  = POS_W'(1) << FRAC;
    localparam logic [POS_W-1:0] STEP_MIN = POS_W'(1) << (FRAC - 4);
    localparam logic [POS_W-1:0] STEP_MAX = POS_W'(8) << FRAC;
    localparam int MAX_RESULTS = 32;
    localparam int DRAIN_WAIT  = 200;
    localparam int HOLD_CYCLES = 600;
    localparam int STUCK_LIMIT = 5000;
    localparam int NROWS       = 24;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic                run_last;
    } frame_result_t;

    typedef struct packed {
        logic                is_cfg;
        logic [POS_W-1:0]    cfg_val;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic                last;
        logic                typed;
        logic [1:0]          n_typed;
        logic [SAMPLE_W-1:0] e0_left;
        logic [SAMPLE_W-1:0] e0_right;
        logic [SAMPLE_W-1:0] e1_left;
        logic [SAMPLE_W-1:0] e1_right;
    } stim_row_t;

    // cfg rows set the step for the frame rows after them; typed rows carry their outputs directly
    localparam stim_row_t ROWS [0:NROWS-1] = '{
        '{1'b0, 20'h0, 16'h7FFF, 16'h8000, 1'b0, 1'b1, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{1'b0, 20'h0, 16'h8000, 16'h7FFF, 1'b0, 1'b1, 2'd1,
          16'h7FFF, 16'h8000, 16'h0, 16'h0},
        '{1'b0, 20'h0, 16'h1234, 16'hFFFF, 1'b1, 1'b1, 2'd2,
          16'h8000, 16'h7FFF, 16'h1234, 16'hFFFF},
        '{1'b0, 20'h0, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 2'd1,
          16'hFFFF, 16'h0000, 16'h0, 16'h0},
        '{1'b0, 20'h0, 16'h5555, 16'hAAAA, 1'b0, 1'b1, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{1'b0, 20'h0, 16'hAAAA, 16'h5555, 1'b0, 1'b1, 2'd1,
          16'h5555, 16'hAAAA, 16'h0, 16'h0},
        '{1'b0, 20'h0, 16'h0000, 16'h0000, 1'b1, 1'b1, 2'd2,
          16'hAAAA, 16'h5555, 16'h0000, 16'h0000},
        // below range, clamps to 1/16: a full packet end gives 32 outputs
        '{1'b1, 20'h00000, 16'h0, 16'h0, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{1'b0, 20'h0, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{1'b0, 20'h0, 16'h8000, 16'h7FFF, 1'b1, 1'b0, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{1'b0, 20'h0, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{1'b0, 20'h0, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{1'b0, 20'h0, 16'h0001, 16'hFFFF, 1'b1, 1'b0, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0},
        // above range, clamps to 8.0: most frames give nothing
        '{1'b1, 20'hFFFFF, 16'h0, 16'h0, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{1'b0, 20'h0, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{1'b0, 20'h0, 16'h8000, 16'h8000, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{1'b0, 20'h0, 16'h1111, 16'hEEEE, 1'b1, 1'b0, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{1'b0, 20'h0, 16'h2222, 16'hDDDD, 1'b1, 1'b0, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{1'b0, 20'h0, 16'h3333, 16'hCCCC, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{1'b1, 20'h18000, 16'h0, 16'h0, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{1'b0, 20'h0, 16'h4444, 16'hBBBB, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{1'b0, 20'h0, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{1'b0, 20'h0, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{1'b0, 20'h0, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0}
    };

    logic                clk;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [POS_W-1:0]    cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;
    logic                m_tlast;

    // model state
    logic [POS_W-1:0]    step_q;
    logic [POS_W-1:0]    read_pos;
    logic [SAMPLE_W-1:0] held_left;
    logic [SAMPLE_W-1:0] held_right;
    logic                held_ok;

    frame_result_t       frame_q[$];
    frame_result_t       typed_q[$];
    frame_result_t       pending_outputs[$];
    frame_result_t       oldest;
    logic                use_typed = 1'b0;

    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    logic                hold_go = 1'b0;
    logic                hold_taken = 1'b0;
    int                  hold_cnt = 0;
    int                  stuck_cycles = 0;
    int                  mismatches = 0;
    int                  sent;
    int                  plen;

    stereo_linear_resampler_core #(
        .FRAC_BITS(FRAC)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [SAMPLE_W-1:0] blend_sample(logic signed [SAMPLE_W-1:0] a,
                                                          logic signed [SAMPLE_W-1:0] b,
                                                          logic [POS_W-1:0] frac);
        longint total;
        longint v;
        total = longint'(a) * longint'(ONE_POS)
              + (longint'(b) - longint'(a)) * longint'(frac);
        v = total / longint'(ONE_POS);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[SAMPLE_W-1:0];
    endfunction

    // walk every position below one frame between the two endpoints
    function automatic void emit_interval(logic [SAMPLE_W-1:0] a_l, logic [SAMPLE_W-1:0] a_r,
                                          logic [SAMPLE_W-1:0] b_l, logic [SAMPLE_W-1:0] b_r);
        frame_result_t res;
        while (read_pos < ONE_POS && frame_q.size() < MAX_RESULTS)
        begin
            res.left = blend_sample(a_l, b_l, read_pos);
            res.right = blend_sample(a_r, b_r, read_pos);
            res.run_last = 1'b0;
            frame_q.insert(frame_q.size(), res);
            read_pos = read_pos + step_q;
        end
        read_pos = read_pos - ONE_POS;
    endfunction

    function automatic void predict_frame(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r,
                                          logic last);
        frame_result_t res;
        frame_q.delete();
        if (held_ok)
            emit_interval(held_left, held_right, l, r);
        if (last)
        begin
            emit_interval(l, r, l, r);
            held_ok = 1'b0;
            held_left = '0;
            held_right = '0;
        end
        else
        begin
            held_left = l;
            held_right = r;
            held_ok = 1'b1;
        end
        if (frame_q.size() > 0)
        begin
            res = frame_q[frame_q.size() - 1];
            res.run_last = 1'b1;
            frame_q[frame_q.size() - 1] = res;
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9, 0))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return SAMPLE_W'($urandom_range(16'hFFFF, 0));
        endcase
    endfunction

    task automatic send_frame(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r, logic last);
        if ($urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99, 0) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r, l};
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_frame(l, r, last);
        if (use_typed)
            foreach (typed_q[i])
                pending_outputs.insert(pending_outputs.size(), typed_q[i]);
        else
            foreach (frame_q[i])
                pending_outputs.insert(pending_outputs.size(), frame_q[i]);
    endtask

    // drain outputs, then let a zero-output frame finish inside the block
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_step(logic [POS_W-1:0] value);
        cfg_wr_data <= value;
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (value < STEP_MIN)
            value = STEP_MIN;
        if (value > STEP_MAX)
            value = STEP_MAX;
        step_q = value;
    endtask

    always @(posedge clk)
    begin
        if (hold_go && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_outputs.size() == 0)
            begin
                $error("unexpected output: tdata %h tlast %b", m_tdata, m_tlast);
                mismatches++;
            end
            else
            begin
                oldest = pending_outputs[0];
                pending_outputs.delete(0);
                if (m_tdata[15:0] !== oldest.left)
                begin
                    $error("left_out: expected %0d, got %0d",
                           $signed(oldest.left), $signed(m_tdata[15:0]));
                    mismatches++;
                end
                if (m_tdata[31:16] !== oldest.right)
                begin
                    $error("right_out: expected %0d, got %0d",
                           $signed(oldest.right), $signed(m_tdata[31:16]));
                    mismatches++;
                end
                if (m_tlast !== oldest.run_last)
                begin
                    $error("run_last: expected %0d, got %0d", oldest.run_last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles == STUCK_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        step_q = ONE_POS;
        read_pos = '0;
        held_left = '0;
        held_right = '0;
        held_ok = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NROWS; i++)
        begin
            if (ROWS[i].is_cfg)
            begin
                settle();
                write_step(ROWS[i].cfg_val);
            end
            else
            begin
                use_typed = ROWS[i].typed;
                typed_q.delete();
                if (ROWS[i].n_typed > 0)
                    typed_q.insert(typed_q.size(), '{ROWS[i].e0_left, ROWS[i].e0_right,
                                                      ROWS[i].n_typed == 1});
                if (ROWS[i].n_typed > 1)
                    typed_q.insert(typed_q.size(),
                                   '{ROWS[i].e1_left, ROWS[i].e1_right, 1'b1});
                send_frame(ROWS[i].left, ROWS[i].right, ROWS[i].last);
            end
        end
        use_typed = 1'b0;

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            for (int seg = 0; seg < 4; seg++)
            begin
                settle();
                case ($urandom_range(7, 0))
                    0: write_step(POS_W'($urandom_range(STEP_MIN - 1, 0)));
                    1: write_step(POS_W'($urandom_range(20'hFFFFF, STEP_MAX + 1)));
                    2: write_step(STEP_MIN);
                    3: write_step(STEP_MAX);
                    default: write_step(POS_W'($urandom_range(3 * ONE_POS, STEP_MIN)));
                endcase
                // long output hold-off while requests keep coming
                if (ph == 0 && seg == 1)
                    hold_go = 1'b1;
                sent = 0;
                while (sent < 22)
                begin
                    plen = $urandom_range(8, 1);
                    for (int k = 0; k < plen; k++)
                    begin
                        send_frame(rand_sample(), rand_sample(), k == plen - 1);
                        sent++;
                    end
                end
            end
        end

        settle();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
